/* hdl/dsgpm_pkg.sv */
// Shared constants and types for the dual gain/pan mixer.
`timescale 1ns / 1ps

package dsgpm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned DB_TABLE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam int unsigned DB_W   = 16;
  localparam int unsigned ENV_W  = 16;
  localparam int unsigned PAN_W  = 4;
  localparam int unsigned PAD_W  = 16;
  localparam int unsigned TAB_W  = 24;
  localparam int unsigned SMTH_W = 32;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // smoothing step 0.001 in Q20, dB to octaves in Q24
  localparam int SMOOTH_K   = 1049;
  localparam int OCT_PER_DB = 10885;

  typedef longint unsigned u64_t;

  localparam u64_t LN2_Q32 = 64'd2977044472;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_PAN  = 3'd0,
    CFG_LOWER_PAN  = 3'd1,
    CFG_UPPER_GAIN = 3'd2,
    CFG_LOWER_GAIN = 3'd3,
    CFG_PAD_GAIN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_GAIN_S,
    BK_GAIN_L,
    BK_PAD,
    BK_MANT,
    BK_ENV,
    BK_ROUND,
    BK_MIX,
    BK_LAYER,
    BK_PAN_SUM,
    BK_PAN_MUL,
    BK_PAN_DIV,
    BK_OUT
  } back_state_e;

endpackage

/* hdl/dsgpm_in_if.sv */
// Input channel: one beat carries both samples, envelope, targets and restart.
`timescale 1ns / 1ps

interface dsgpm_in_if #(
  parameter int unsigned SAMPLE_BITS = dsgpm_pkg::SAMPLE_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [SAMPLE_BITS-1:0]       upper_in;
  logic signed [SAMPLE_BITS-1:0]       lower_in;
  logic        [dsgpm_pkg::ENV_W-1:0]  envelope;
  logic signed [dsgpm_pkg::DB_W-1:0]   target_upper_db;
  logic signed [dsgpm_pkg::DB_W-1:0]   target_lower_db;
  logic                                restart;

  modport source (
    output valid, upper_in, lower_in, envelope, target_upper_db, target_lower_db, restart,
    input  ready
  );
  modport sink (
    input  valid, upper_in, lower_in, envelope, target_upper_db, target_lower_db, restart,
    output ready
  );
endinterface

/* hdl/dsgpm_out_if.sv */
// Output channel: one beat carries both mixed samples and the smoothed gains.
`timescale 1ns / 1ps

interface dsgpm_out_if #(
  parameter int unsigned SAMPLE_BITS = dsgpm_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_BITS-1:0]     upper_out;
  logic signed [SAMPLE_BITS-1:0]     lower_out;
  logic signed [dsgpm_pkg::DB_W-1:0] smoothed_upper_db;
  logic signed [dsgpm_pkg::DB_W-1:0] smoothed_lower_db;

  modport source (
    output valid, upper_out, lower_out, smoothed_upper_db, smoothed_lower_db,
    input  ready
  );
  modport sink (
    input  valid, upper_out, lower_out, smoothed_upper_db, smoothed_lower_db,
    output ready
  );
endinterface

/* hdl/dsgpm_front.sv */
// Front end: accepts input beats, runs both one-pole dB smoothers, queues the work.
`timescale 1ns / 1ps

module dsgpm_front #(
  parameter int unsigned SAMPLE_BITS = dsgpm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  dsgpm_in_if.sink                             in_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        upper_in_o,
  output logic signed [SAMPLE_BITS-1:0]        lower_in_o,
  output logic        [dsgpm_pkg::ENV_W-1:0]   envelope_o,
  output logic signed [dsgpm_pkg::DB_W-1:0]    smoothed_upper_db_o,
  output logic signed [dsgpm_pkg::DB_W-1:0]    smoothed_lower_db_o
);
  import dsgpm_pkg::*;

  logic signed [SMTH_W-1:0] su_q, su_d;
  logic signed [SMTH_W-1:0] sl_q, sl_d;
  logic                     accept;

  // s + floor((t*2^16 - s) * k / 2^20)
  function automatic logic signed [SMTH_W-1:0] smooth_step(
    input logic signed [SMTH_W-1:0] s,
    input logic signed [DB_W-1:0]   t
  );
    logic signed [SMTH_W:0]    diff;
    logic signed [SMTH_W+12:0] prod;
    diff = (SMTH_W+1)'($signed({t, 16'h0000})) - (SMTH_W+1)'(s);
    prod = (SMTH_W+13)'(diff) * (SMTH_W+13)'(SMOOTH_K);
    return s + SMTH_W'($signed(prod[SMTH_W+12:20]));
  endfunction

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid & push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    su_d = smooth_step(in_i.restart ? '0 : su_q, in_i.target_upper_db);
    sl_d = smooth_step(in_i.restart ? '0 : sl_q, in_i.target_lower_db);
  end

  assign upper_in_o          = in_i.upper_in;
  assign lower_in_o          = in_i.lower_in;
  assign envelope_o          = in_i.envelope;
  assign smoothed_upper_db_o = su_d[SMTH_W-1 -: DB_W];
  assign smoothed_lower_db_o = sl_d[SMTH_W-1 -: DB_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_q <= '0;
      sl_q <= '0;
    end else if (accept) begin
      su_q <= su_d;
      sl_q <= sl_d;
    end
  end

endmodule

/* hdl/dsgpm_queue.sv */
// Short register FIFO between the front and back ends.
`timescale 1ns / 1ps

module dsgpm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/dsgpm_back.sv */
// Back end: sequencer over one shared multiplier for gain, scaling and divide.
`timescale 1ns / 1ps

module dsgpm_back #(
  parameter int unsigned SAMPLE_BITS    = dsgpm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DB_TABLE_DEPTH = dsgpm_pkg::DB_TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       upper_in_i,
  input  logic signed [SAMPLE_BITS-1:0]       lower_in_i,
  input  logic        [dsgpm_pkg::ENV_W-1:0]  envelope_i,
  input  logic signed [dsgpm_pkg::DB_W-1:0]   smoothed_upper_db_i,
  input  logic signed [dsgpm_pkg::DB_W-1:0]   smoothed_lower_db_i,
  input  logic signed [dsgpm_pkg::PAN_W-1:0]  upper_pan_i,
  input  logic signed [dsgpm_pkg::PAN_W-1:0]  lower_pan_i,
  input  logic signed [dsgpm_pkg::DB_W-1:0]   upper_layer_gain_db_i,
  input  logic signed [dsgpm_pkg::DB_W-1:0]   lower_layer_gain_db_i,
  input  logic        [dsgpm_pkg::PAD_W-1:0]  pad_gain_i,
  dsgpm_out_if.source                         out_o
);
  import dsgpm_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned AW = (SB + 7 > TAB_W + 1) ? SB + 7 : TAB_W + 1;
  localparam int unsigned BW = (SB + 1 > TAB_W + 1) ? SB + 1 : TAB_W + 1;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned RW = SB + 18;   // layer result, |x| <= 2^(SB+16)
  localparam int unsigned SW = SB + 22;   // pan sum
  localparam int unsigned HW = SB + 2;    // half-sum fed to the divide by 7
  localparam int unsigned IW = $clog2(DB_TABLE_DEPTH);

  localparam logic [SB-1:0]        R7   = SB'((u64_t'(1) << (SB + 2)) / 7);
  localparam logic [PW:0]          LIM  = (PW + 1)'(1) << (SB + 16);
  localparam logic [SW-1:0]        HSAT = SW'(7) << (SB - 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

  // 2^(i/DEPTH) in Q2.22, constant table; 16-term series of y = i*ln2/DEPTH in Q32
  logic [TAB_W-1:0] db_tab [DB_TABLE_DEPTH];
  for (genvar g = 0; g < DB_TABLE_DEPTH; g++) begin : g_tab
    localparam u64_t Y   = (u64_t'(g) * LN2_Q32) / DB_TABLE_DEPTH;
    localparam u64_t T0  = u64_t'(1) << 32;
    localparam u64_t T1  = ((T0 * Y) >> 32) / 1;
    localparam u64_t T2  = ((T1 * Y) >> 32) / 2;
    localparam u64_t T3  = ((T2 * Y) >> 32) / 3;
    localparam u64_t T4  = ((T3 * Y) >> 32) / 4;
    localparam u64_t T5  = ((T4 * Y) >> 32) / 5;
    localparam u64_t T6  = ((T5 * Y) >> 32) / 6;
    localparam u64_t T7  = ((T6 * Y) >> 32) / 7;
    localparam u64_t T8  = ((T7 * Y) >> 32) / 8;
    localparam u64_t T9  = ((T8 * Y) >> 32) / 9;
    localparam u64_t T10 = ((T9 * Y) >> 32) / 10;
    localparam u64_t T11 = ((T10 * Y) >> 32) / 11;
    localparam u64_t T12 = ((T11 * Y) >> 32) / 12;
    localparam u64_t T13 = ((T12 * Y) >> 32) / 13;
    localparam u64_t T14 = ((T13 * Y) >> 32) / 14;
    localparam u64_t T15 = ((T14 * Y) >> 32) / 15;
    localparam u64_t TSUM = T0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10 +
                            T11 + T12 + T13 + T14 + T15;
    localparam logic [TAB_W-1:0] TVAL = TAB_W'((TSUM + u64_t'(512)) >> 10);
    assign db_tab[g] = TVAL;
  end

  back_state_e state_q, state_d;
  logic        sel_q, sel_d;
  logic        ovalid_q, load_out;

  // work registers
  logic signed [SB-1:0]    ui_q, li_q;
  logic        [ENV_W-1:0] env_q;
  logic signed [DB_W-1:0]  du_q, dl_q;
  logic signed [5:0]       os_q, ol_q;
  logic        [IW-1:0]    is_q, il_q;
  logic signed [SB+4:0]    a_q;
  logic signed [SB+5:0]    b_q;
  logic        [TAB_W-1:0] m_q;
  logic signed [RW-1:0]    ru_q, rl_q;
  logic        [HW-1:0]    h_q;
  logic                    neg_q, sat_q;
  logic signed [SB-1:0]    uo_q, lo_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [SB-1:0]    uout_q, lout_q;
  logic signed [DB_W-1:0]  suo_q, slo_q;

  // shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  // product post-processing
  logic                 pneg;
  logic [PW-1:0]        pmag;
  logic [PW-1:0]        r12, r15;
  logic [PW-1:0]        mrnd;
  logic [IW+24:0]       fidx;
  logic [IW-1:0]        idx_d;
  logic signed [5:0]    oct_d;
  logic signed [SB+4:0] a_d;
  logic signed [SB+5:0] b_d;
  logic signed [7:0]    sc;
  logic [PW:0]          tmag, rnd, smag;
  logic [6:0]           rsh;
  logic [4:0]           lsh;
  logic signed [RW-1:0] layer_d;

  // pan and divide
  logic signed [PAN_W-1:0] pu, pl;
  logic signed [4:0]       cu, cl;
  logic signed [SW-1:0]    psum;
  logic [SW-1:0]           pmag_s, hfull;
  logic [SB-1:0]           q0, qf;
  logic [SB+2:0]           q7;
  logic [HW-1:0]           rem;
  logic signed [SB-1:0]    div_d;

  always_comb begin
    pneg  = prod_q[PW-1];
    pmag  = pneg ? PW'(-prod_q) : PW'(prod_q);
    r12   = (pmag + (PW'(1) << 11)) >> 12;
    r15   = (pmag + (PW'(1) << 14)) >> 15;
    mrnd  = (pmag + (PW'(1) << 21)) >> 22;
    a_d   = pneg ? -(SB + 5)'(r12) : (SB + 5)'(r12);
    b_d   = pneg ? -(SB + 6)'(r15) : (SB + 6)'(r15);
    oct_d = prod_q[29:24];
    fidx  = (IW + 25)'(prod_q[23:0]) * (IW + 25)'(DB_TABLE_DEPTH);
    idx_d = fidx[24 +: IW];

    // scale by 2^(os+ol-22), round half away from zero, saturate
    sc   = 8'sd22 - (8'(os_q) + 8'(ol_q));
    rsh  = '0;
    lsh  = '0;
    tmag = '0;
    rnd  = '0;
    if (sc > 8'sd0) begin
      rsh  = 7'(sc - 8'sd1);
      tmag = {1'b0, pmag} >> rsh;
      rnd  = (tmag + (PW + 1)'(1)) >> 1;
      smag = (rnd > LIM) ? LIM : rnd;
    end else if (sc < 8'sd0) begin
      lsh = 5'(-sc);
      if ((pmag >> (SB + 16 - lsh)) != '0) begin
        smag = LIM;
      end else begin
        smag = {1'b0, pmag} << lsh;
      end
    end else begin
      smag = ({1'b0, pmag} > LIM) ? LIM : {1'b0, pmag};
    end
    layer_d = pneg ? -RW'(smag) : RW'(smag);

    // pan matrix, a pan code of -8 acts as -7
    pu   = (upper_pan_i == 4'sb1000) ? -4'sd7 : upper_pan_i;
    pl   = (lower_pan_i == 4'sb1000) ? -4'sd7 : lower_pan_i;
    cu   = sel_q ? (5'sd7 + 5'(pu)) : (5'sd7 - 5'(pu));
    cl   = sel_q ? (5'sd7 + 5'(pl)) : (5'sd7 - 5'(pl));
    psum = SW'(ru_q) * SW'(cu) + SW'(rl_q) * SW'(cl);
    pmag_s = psum[SW-1] ? SW'(-psum) : SW'(psum);
    hfull  = (pmag_s + SW'(7)) >> 1;

    // floor(h/7): reciprocal estimate, one correction step
    q0    = prod_q[HW +: SB];
    q7    = {q0, 3'b000} - {3'b000, q0};
    rem   = h_q - HW'(q7);
    qf    = (rem >= HW'(7)) ? q0 + SB'(1) : q0;
    if (sat_q) begin
      div_d = neg_q ? SMIN : SMAX;
    end else begin
      div_d = neg_q ? -$signed(qf) : $signed(qf);
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = BK_GAIN_S;
          sel_d   = 1'b0;
        end
      end
      BK_GAIN_S: begin
        mul_a   = AW'(sel_q ? dl_q : du_q);
        mul_b   = BW'(OCT_PER_DB);
        state_d = BK_GAIN_L;
      end
      BK_GAIN_L: begin
        mul_a   = AW'(sel_q ? lower_layer_gain_db_i : upper_layer_gain_db_i);
        mul_b   = BW'(OCT_PER_DB);
        state_d = BK_PAD;
      end
      BK_PAD: begin
        mul_a   = AW'(sel_q ? li_q : ui_q);
        mul_b   = BW'({1'b0, pad_gain_i});
        state_d = BK_MANT;
      end
      BK_MANT: begin
        mul_a   = AW'({1'b0, db_tab[is_q]});
        mul_b   = BW'({1'b0, db_tab[il_q]});
        state_d = BK_ENV;
      end
      BK_ENV: begin
        mul_a   = AW'(a_q);
        mul_b   = BW'({1'b0, env_q});
        state_d = BK_ROUND;
      end
      // envelope product rounds into b_q before the final multiply
      BK_ROUND: begin
        state_d = BK_MIX;
      end
      BK_MIX: begin
        mul_a   = AW'(b_q);
        mul_b   = BW'({1'b0, m_q});
        state_d = BK_LAYER;
      end
      BK_LAYER: begin
        sel_d   = ~sel_q;
        state_d = sel_q ? BK_PAN_SUM : BK_GAIN_S;
      end
      BK_PAN_SUM: begin
        state_d = BK_PAN_MUL;
      end
      BK_PAN_MUL: begin
        mul_a   = AW'({1'b0, h_q});
        mul_b   = BW'({1'b0, R7});
        state_d = BK_PAN_DIV;
      end
      BK_PAN_DIV: begin
        sel_d   = ~sel_q;
        state_d = sel_q ? BK_OUT : BK_PAN_SUM;
      end
      BK_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      sel_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          ui_q  <= upper_in_i;
          li_q  <= lower_in_i;
          env_q <= envelope_i;
          du_q  <= smoothed_upper_db_i;
          dl_q  <= smoothed_lower_db_i;
        end
      end
      BK_GAIN_L: begin
        os_q <= oct_d;
        is_q <= idx_d;
      end
      BK_PAD: begin
        ol_q <= oct_d;
        il_q <= idx_d;
      end
      BK_MANT:  a_q <= a_d;
      BK_ENV:   m_q <= mrnd[TAB_W-1:0];
      BK_ROUND: b_q <= b_d;
      BK_LAYER: begin
        if (sel_q) begin
          rl_q <= layer_d;
        end else begin
          ru_q <= layer_d;
        end
      end
      BK_PAN_SUM: begin
        h_q   <= hfull[HW-1:0];
        neg_q <= psum[SW-1];
        sat_q <= (hfull >= HSAT);
      end
      BK_PAN_DIV: begin
        if (sel_q) begin
          lo_q <= div_d;
        end else begin
          uo_q <= div_d;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      uout_q <= uo_q;
      lout_q <= lo_q;
      suo_q  <= du_q;
      slo_q  <= dl_q;
    end
  end

  assign out_o.valid             = ovalid_q;
  assign out_o.upper_out         = uout_q;
  assign out_o.lower_out         = lout_q;
  assign out_o.smoothed_upper_db = suo_q;
  assign out_o.smoothed_lower_db = slo_q;

endmodule

/* hdl/dual_smoothed_gain_pan_mixer.sv */
// Top level of the two-layer smoothed gain and pan mixer.
`timescale 1ns / 1ps

// Two-layer gain/pan mixer. Each input beat carries an upper and a lower
// Q5.(SAMPLE_BITS-5) sample, a Q1.15 envelope, two Q8.8 dB target gains and a
// restart flag. The front end keeps one one-pole smoother per layer (step
// 0.001 toward the target, cleared first on restart) and hands the beat plus
// the updated smoothed gains to a two-entry queue, so input beats keep being
// taken while the back end works. The back end converts dB to a mantissa from
// a 2^(i/DB_TABLE_DEPTH) constant table and an octave shift, scales each
// sample by pad, envelope, smoothed gain and fixed layer gain, then mixes the
// layers through the pan matrix (pan/7 blend, divide by 14 with rounding) and
// saturates to the sample range. The gain, scaling and divide products go
// through one shared registered multiplier, so the back end takes one item at a
// time: pop, each layer's steps, pan sum and divide per output channel, output
// load. One result beat per input beat, in order; the result sits in an output
// register until taken. Configuration: write cfg_data_i to register
// cfg_idx_i (0 upper pan, 1 lower pan, 2 upper layer gain, 3 lower layer gain,
// 4 pad gain) while cfg_we_i is high; write only while no item is in flight.
module dual_smoothed_gain_pan_mixer #(
  parameter int unsigned SAMPLE_BITS    = dsgpm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DB_TABLE_DEPTH = dsgpm_pkg::DB_TABLE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  dsgpm_in_if.sink                              in_i,
  dsgpm_out_if.source                           out_o,
  input  logic                                  cfg_we_i,
  input  logic [dsgpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dsgpm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import dsgpm_pkg::*;

  localparam int unsigned QW = 2 * SAMPLE_BITS + ENV_W + 2 * DB_W;

  // config registers
  logic signed [PAN_W-1:0] upper_pan_q, lower_pan_q;
  logic signed [DB_W-1:0]  upper_gain_q, lower_gain_q;
  logic        [PAD_W-1:0] pad_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_pan_q  <= '0;
      lower_pan_q  <= '0;
      upper_gain_q <= '0;
      lower_gain_q <= '0;
      pad_gain_q   <= PAD_W'(4096);  // unity in Q4.12
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPPER_PAN:  upper_pan_q  <= cfg_data_i[PAN_W-1:0];
        CFG_LOWER_PAN:  lower_pan_q  <= cfg_data_i[PAN_W-1:0];
        CFG_UPPER_GAIN: upper_gain_q <= cfg_data_i[DB_W-1:0];
        CFG_LOWER_GAIN: lower_gain_q <= cfg_data_i[DB_W-1:0];
        CFG_PAD_GAIN:   pad_gain_q   <= cfg_data_i[PAD_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // front -> queue
  logic                          f_valid, f_ready;
  logic signed [SAMPLE_BITS-1:0] f_upper, f_lower;
  logic        [ENV_W-1:0]       f_env;
  logic signed [DB_W-1:0]        f_du, f_dl;
  logic        [QW-1:0]          q_push_data, q_pop_data;

  // queue -> back
  logic                          b_valid, b_ready;
  logic signed [SAMPLE_BITS-1:0] b_upper, b_lower;
  logic        [ENV_W-1:0]       b_env;
  logic signed [DB_W-1:0]        b_du, b_dl;

  dsgpm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_i                (in_i),
    .push_valid_o        (f_valid),
    .push_ready_i        (f_ready),
    .upper_in_o          (f_upper),
    .lower_in_o          (f_lower),
    .envelope_o          (f_env),
    .smoothed_upper_db_o (f_du),
    .smoothed_lower_db_o (f_dl)
  );

  assign q_push_data = {f_upper, f_lower, f_env, f_du, f_dl};

  dsgpm_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_pop_data)
  );

  assign {b_upper, b_lower, b_env, b_du, b_dl} = q_pop_data;

  dsgpm_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .DB_TABLE_DEPTH (DB_TABLE_DEPTH)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .pop_valid_i           (b_valid),
    .pop_ready_o           (b_ready),
    .upper_in_i            (b_upper),
    .lower_in_i            (b_lower),
    .envelope_i            (b_env),
    .smoothed_upper_db_i   (b_du),
    .smoothed_lower_db_i   (b_dl),
    .upper_pan_i           (upper_pan_q),
    .lower_pan_i           (lower_pan_q),
    .upper_layer_gain_db_i (upper_gain_q),
    .lower_layer_gain_db_i (lower_gain_q),
    .pad_gain_i            (pad_gain_q),
    .out_o                 (out_o)
  );

endmodule

/* sim/tb_dual_smoothed_gain_pan_mixer.sv */
// Self-checking testbench for the two-layer smoothed gain and pan mixer.
`timescale 1ns / 1ps

module tb_dual_smoothed_gain_pan_mixer;
  import dsgpm_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int TDEPTH = DB_TABLE_DEPTH_DEF;
  localparam int RAND_BLOCKS = 12;
  localparam int BLOCK_BEATS = 150;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [SB-1:0]   upper;
    logic signed [SB-1:0]   lower;
    logic [ENV_W-1:0]       env;
    logic signed [DB_W-1:0] tgt_u;
    logic signed [DB_W-1:0] tgt_l;
    logic                   restart;
  } mix_beat_t;

  typedef struct {
    logic signed [SB-1:0]   upper;
    logic signed [SB-1:0]   lower;
    logic signed [DB_W-1:0] sm_u;
    logic signed [DB_W-1:0] sm_l;
  } mix_result_t;

  // Mirror of the mixer: registers, smoother state, 2^x table, expected beats.
  class mix_scoreboard;
    int                pan_u, pan_l;
    longint            gain_u, gain_l, pad;
    longint            sm_u, sm_l;
    longint unsigned   exp2_tab[TDEPTH];
    mix_result_t       pending_q[$];
    int                errors;
    int                checked;

    function new();
      longint unsigned y, term, sum;
      pan_u = 0; pan_l = 0; gain_u = 0; gain_l = 0; pad = 4096;
      sm_u = 0; sm_l = 0; errors = 0; checked = 0;
      // 2^(i/DEPTH) in Q2.22 by a 16-term exp series of i*ln2/DEPTH
      for (int i = 0; i < TDEPTH; i++) begin
        y = (longint'(i) * LN2_Q32) / TDEPTH;
        term = 64'd1 << 32;
        sum = term;
        for (int k = 1; k <= 15; k++) begin
          term = ((term * y) >> 32) / k;
          sum += term;
        end
        exp2_tab[i] = (sum + 512) >> 10;
      end
    endfunction

    function void write_reg(int idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_UPPER_PAN:  pan_u = $signed(v[PAN_W-1:0]);
        CFG_LOWER_PAN:  pan_l = $signed(v[PAN_W-1:0]);
        CFG_UPPER_GAIN: gain_u = $signed(v);
        CFG_LOWER_GAIN: gain_l = $signed(v);
        CFG_PAD_GAIN:   pad = v;
        default: ;
      endcase
    endfunction

    // dB (Q8.8) to table mantissa and octave
    function void db_split(longint x, output longint unsigned mant, output int oct);
      longint l, o;
      longint unsigned frac;
      l = x * OCT_PER_DB;
      o = l >>> 24;
      frac = l - (o <<< 24);
      frac = (frac * TDEPTH) >> 24;
      if (frac >= TDEPTH) frac = TDEPTH - 1;
      mant = exp2_tab[frac];
      oct = int'(o);
    endfunction

    // v / 2^s, round half away from zero, saturate to +-lim
    function longint sat_shift(longint v, int s, longint lim);
      longint unsigned mag, ulim;
      bit neg;
      ulim = lim;
      neg = v < 0;
      mag = neg ? -v : v;
      if (s > 0)
        mag = (s > 62) ? 0 : ((mag + (64'd1 << (s - 1))) >> s);
      else if (s < 0) begin
        if (mag != 0 && (-s >= 62 || mag > (ulim >> -s))) mag = ulim;
        else mag = mag << -s;
      end
      if (mag > ulim) mag = ulim;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function longint layer_level(longint smp, longint env, longint sdb, longint ldb);
      longint unsigned ms, ml, m;
      int os, ol;
      longint lim, a, b;
      lim = longint'(1) << (SB + 16);
      db_split(sdb, ms, os);
      db_split(ldb, ml, ol);
      m = (ms * ml + (64'd1 << 21)) >> 22;
      a = sat_shift(smp * pad, 12, lim);
      b = sat_shift(a * env, 15, lim);
      return sat_shift(b * longint'(m), 22 - (os + ol), lim);
    endfunction

    function longint pan_round(longint v);
      longint unsigned mag;
      longint r, smax;
      smax = (longint'(1) << (SB - 1)) - 1;
      mag = (v < 0) ? -v : v;
      mag = (mag + 7) / 14;
      r = (v < 0) ? -longint'(mag) : longint'(mag);
      if (r > smax) r = smax;
      if (r < -smax - 1) r = -smax - 1;
      return r;
    endfunction

    function longint smooth_step(longint s, longint t);
      return s + (((t * 65536 - s) * SMOOTH_K) >>> 20);
    endfunction

    function longint db_floor(longint s);
      longint r;
      r = s >>> 16;
      return (r > 32767) ? 32767 : ((r < -32768) ? -32768 : r);
    endfunction

    function void note_input(mix_beat_t it);
      mix_result_t e;
      longint du, dl, ru, rl;
      int pu, pl;
      pu = (pan_u < -7) ? -7 : pan_u;  // pan code -8 acts as -7
      pl = (pan_l < -7) ? -7 : pan_l;
      if (it.restart) begin
        sm_u = 0;
        sm_l = 0;
      end
      sm_u = smooth_step(sm_u, it.tgt_u);
      sm_l = smooth_step(sm_l, it.tgt_l);
      du = db_floor(sm_u);
      dl = db_floor(sm_l);
      ru = layer_level(it.upper, it.env, du, gain_u);
      rl = layer_level(it.lower, it.env, dl, gain_l);
      e.upper = SB'(pan_round(ru * (7 - pu) + rl * (7 - pl)));
      e.lower = SB'(pan_round(ru * (7 + pu) + rl * (7 + pl)));
      e.sm_u = DB_W'(du);
      e.sm_l = DB_W'(dl);
      pending_q.push_back(e);
    endfunction

    function void check_result(mix_result_t r);
      mix_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat upper=%0d lower=%0d", $time, r.upper, r.lower);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (r.upper !== e.upper) begin
        errors++;
        $display("%0t: upper_out exp %0d got %0d", $time, e.upper, r.upper);
      end
      if (r.lower !== e.lower) begin
        errors++;
        $display("%0t: lower_out exp %0d got %0d", $time, e.lower, r.lower);
      end
      if (r.sm_u !== e.sm_u) begin
        errors++;
        $display("%0t: smoothed_upper_db exp %0d got %0d", $time, e.sm_u, r.sm_u);
      end
      if (r.sm_l !== e.sm_l) begin
        errors++;
        $display("%0t: smoothed_lower_db exp %0d got %0d", $time, e.sm_l, r.sm_l);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dsgpm_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  dsgpm_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  dual_smoothed_gain_pan_mixer #(
    .SAMPLE_BITS(SB),
    .DB_TABLE_DEPTH(TDEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch),
    .out_o(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  mix_scoreboard mixer_sb = new();
  int send_idle;   // percent of cycles the sender holds back
  int recv_idle;   // percent of cycles the receiver stalls
  int beats_sent;
  int restarts;
  int cfg_writes;
  logic signed [DB_W-1:0] cur_tu, cur_tl;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: ready changes on the falling edge, beats checked on the rising one.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    mix_result_t r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      r.upper = out_ch.upper_out;
      r.lower = out_ch.lower_out;
      r.sm_u = out_ch.smoothed_upper_db;
      r.sm_l = out_ch.smoothed_lower_db;
      mixer_sb.check_result(r);
    end
  end

  task automatic cfg_write(int idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx[CFG_IDX_W-1:0];
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mixer_sb.write_reg(idx, v);
    cfg_writes++;
  endtask

  // Wait until every expected beat is back, then let the back end settle.
  task automatic drain();
    while (mixer_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Drive one beat; called right after a falling edge.
  task automatic send(mix_beat_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.upper_in = it.upper;
    in_ch.lower_in = it.lower;
    in_ch.envelope = it.env;
    in_ch.target_upper_db = it.tgt_u;
    in_ch.target_lower_db = it.tgt_l;
    in_ch.restart = it.restart;
    do @(posedge clk_i); while (!in_ch.ready);
    mixer_sb.note_input(it);
    beats_sent++;
    if (it.restart) restarts++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: return '0;
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [ENV_W-1:0] pick_env();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'd32768;
      default: return ENV_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [DB_W-1:0] pick_db();
    case ($urandom_range(7))
      0: return -16'sd24576;
      1: return 16'sd12288;
      2: return '0;
      default: return DB_W'($urandom_range(36864) - 24576);
    endcase
  endfunction

  // Mostly steady targets so the smoothers travel far; a few jumps and key-ons.
  function automatic mix_beat_t rand_beat();
    mix_beat_t it;
    it.restart = ($urandom_range(99) < 3);
    if (it.restart || $urandom_range(99) < 2) begin
      cur_tu = pick_db();
      cur_tl = pick_db();
    end
    it.upper = pick_sample();
    it.lower = pick_sample();
    it.env = pick_env();
    it.tgt_u = ($urandom_range(99) < 5) ? pick_db() : cur_tu;
    it.tgt_l = ($urandom_range(99) < 5) ? pick_db() : cur_tl;
    return it;
  endfunction

  // mode 0: loudest corner, 1: quietest corner, else random
  task automatic set_config(int mode);
    case (mode)
      0: begin
        cfg_write(CFG_UPPER_PAN, 16'h0007);
        cfg_write(CFG_LOWER_PAN, 16'h0008);   // -8, behaves as -7
        cfg_write(CFG_UPPER_GAIN, 16'd12288);
        cfg_write(CFG_LOWER_GAIN, 16'd12288);
        cfg_write(CFG_PAD_GAIN, 16'hFFFF);
      end
      1: begin
        cfg_write(CFG_UPPER_PAN, 16'h0009);   // -7
        cfg_write(CFG_LOWER_PAN, 16'h0007);
        cfg_write(CFG_UPPER_GAIN, 16'hA000);  // -96 dB
        cfg_write(CFG_LOWER_GAIN, 16'hA000);
        cfg_write(CFG_PAD_GAIN, 16'h0000);
      end
      default: begin
        cfg_write(CFG_UPPER_PAN, CFG_DATA_W'($urandom_range(15)));
        cfg_write(CFG_LOWER_PAN, CFG_DATA_W'($urandom_range(15)));
        cfg_write(CFG_UPPER_GAIN, CFG_DATA_W'($urandom_range(36864) - 24576));
        cfg_write(CFG_LOWER_GAIN, CFG_DATA_W'($urandom_range(36864) - 24576));
        cfg_write(CFG_PAD_GAIN,
                  CFG_DATA_W'(($urandom_range(3) == 0) ? 4096 : $urandom_range(65535)));
      end
    endcase
  endtask

  initial begin
    mix_beat_t it;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.upper_in = '0;
    in_ch.lower_in = '0;
    in_ch.envelope = '0;
    in_ch.target_upper_db = '0;
    in_ch.target_lower_db = '0;
    in_ch.restart = 1'b0;
    beats_sent = 0;
    restarts = 0;
    cfg_writes = 0;
    cur_tu = '0;
    cur_tl = '0;
    send_idle = 16;
    recv_idle = 80;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Unused register indexes must be ignored.
    for (int i = CFG_PAD_GAIN + 1; i < (1 << CFG_IDX_W); i++) cfg_write(i, 16'hFFFF);

    // Directed: reset config, sample and envelope extremes, key-on, target extremes.
    for (int i = 0; i < 16; i++) begin
      it.upper = (i % 4 == 0) ? {1'b1, {(SB-1){1'b0}}} :
                 (i % 4 == 1) ? {1'b0, {(SB-1){1'b1}}} : pick_sample();
      it.lower = (i % 4 == 0) ? {1'b0, {(SB-1){1'b1}}} :
                 (i % 4 == 1) ? {1'b1, {(SB-1){1'b0}}} : pick_sample();
      it.env = (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h8000);
      it.tgt_u = (i < 8) ? 16'sd12288 : -16'sd24576;
      it.tgt_l = (i < 8) ? -16'sd24576 : 16'sd12288;
      it.restart = (i == 0 || i == 8 || i == 12);
      send(it);
    end
    stop_sending();
    drain();

    // Saturating corner: maximum pad and gains, full-scale input, pan at both ends.
    set_config(0);
    for (int i = 0; i < 6; i++) begin
      it.upper = (i[0]) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      it.lower = it.upper;
      it.env = 16'hFFFF;
      it.tgt_u = 16'sd12288;
      it.tgt_l = 16'sd12288;
      it.restart = (i == 0);
      send(it);
    end
    stop_sending();
    drain();

    // Random blocks; idling pattern shifts by thirds, config changes per block.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk < RAND_BLOCKS / 3) begin
        send_idle = 16; recv_idle = 80;
      end else if (blk < 2 * RAND_BLOCKS / 3) begin
        send_idle = 80; recv_idle = 16;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      set_config(blk < 2 ? blk + 1 - 2 * (blk % 2) : 2);
      for (int n = 0; n < BLOCK_BEATS; n++) begin
        send(rand_beat());
        // occasionally hold the sender until the pipe is empty
        if ($urandom_range(199) == 0) begin
          stop_sending();
          drain();
        end
      end
      stop_sending();
      drain();
    end

    $display("Sent %0d beats (%0d key-ons), checked %0d results, %0d register writes.",
             beats_sent, restarts, mixer_sb.checked, cfg_writes);
    $display("Covered pan ends, gain and pad extremes, saturation and three idling patterns.");
    if (mixer_sb.errors == 0 && mixer_sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* dual_smoothed_gain_pan_mixer.f */
hdl/dsgpm_pkg.sv
hdl/dsgpm_in_if.sv
hdl/dsgpm_out_if.sv
hdl/dsgpm_front.sv
hdl/dsgpm_queue.sv
hdl/dsgpm_back.sv
hdl/dual_smoothed_gain_pan_mixer.sv
sim/tb_dual_smoothed_gain_pan_mixer.sv
